FILE: sv/dsi64_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dsi64_pkg;

  localparam logic [15:0] MAX_LEN    = 16'hFFFF;
  localparam logic [4:0]  MAX_DIGITS = 5'd20;

  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_WS,
    PH_START,
    PH_ZEROS,
    PH_DIGITS,
    PH_DONE,
    PH_NONUM
  } phase_t;

  typedef enum logic [1:0] {
    ST_POS   = 2'd0,
    ST_NEG   = 2'd1,
    ST_RANGE = 2'd2,
    ST_NONUM = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic [15:0] consumed;
  } out_word_t;

  typedef struct packed {
    logic     valid;
    in_word_t word;
  } stage_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/dsi64_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module dsi64_in_stage (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  dsi64_pkg::in_word_t in_data,
  input  wire                 adv,
  output dsi64_pkg::stage_t   stg
);

  logic                 valid_r;
  dsi64_pkg::in_word_t  word_r;

  assign in_ready = !valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (adv) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_data;
    end
  end

  assign stg.valid = valid_r;
  assign stg.word  = word_r;

endmodule

`default_nettype wire

FILE: sv/dsi64_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module dsi64_parse (
  input  wire                 clk,
  input  wire                 rst_n,
  input  dsi64_pkg::stage_t   stg,
  input  wire                 out_free,
  output logic                adv,
  output dsi64_pkg::result_t  res
);

  dsi64_pkg::phase_t phase_r, phase_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic [4:0]        dcnt_r, dcnt_nxt;
  logic              neg_r, neg_nxt;
  logic              ovf_r, ovf_nxt;
  logic [15:0]       pos_r, pos_nxt;
  logic [15:0]       end_r, end_nxt;

  logic [7:0]  c;
  logic [3:0]  d;
  logic        is_dig;
  logic        is_ws;
  logic        start_sel;
  logic        take;
  logic [67:0] acc10;
  logic [67:0] lim68;
  logic        too_big;
  logic        has_num;

  assign c      = stg.word.char_byte;
  assign d      = c[3:0];
  assign is_dig = c inside {[dsi64_pkg::CH_ZERO:dsi64_pkg::CH_NINE]};
  assign is_ws  = (c == dsi64_pkg::CH_SPACE) || (c == dsi64_pkg::CH_TAB);

  assign acc10   = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {64'd0, d};
  assign lim68   = {4'd0, neg_r ? dsi64_pkg::NEG_LIMIT : dsi64_pkg::POS_LIMIT};
  assign too_big = acc10 > lim68;

  assign adv = stg.valid && (!stg.word.last || out_free);

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    dcnt_nxt  = dcnt_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    pos_nxt   = pos_r;
    end_nxt   = end_r;
    start_sel = 1'b0;
    take      = 1'b0;

    if (pos_r != dsi64_pkg::MAX_LEN) begin
      pos_nxt = pos_r + 16'd1;
      case (phase_r)
        dsi64_pkg::PH_WS: begin
          if (is_ws) begin
            phase_nxt = phase_r;
          end else if (c == dsi64_pkg::CH_MINUS) begin
            neg_nxt   = 1'b1;
            phase_nxt = dsi64_pkg::PH_START;
          end else if (c == dsi64_pkg::CH_PLUS) begin
            phase_nxt = dsi64_pkg::PH_START;
          end else begin
            start_sel = 1'b1;
          end
        end
        dsi64_pkg::PH_START: begin
          start_sel = 1'b1;
        end
        dsi64_pkg::PH_ZEROS: begin
          if (c == dsi64_pkg::CH_ZERO) begin
            end_nxt = pos_r + 16'd1;
          end else if (is_dig) begin
            phase_nxt = dsi64_pkg::PH_DIGITS;
            take      = 1'b1;
          end else begin
            phase_nxt = dsi64_pkg::PH_DONE;
          end
        end
        dsi64_pkg::PH_DIGITS: begin
          if (is_dig) begin
            take = 1'b1;
          end else begin
            phase_nxt = dsi64_pkg::PH_DONE;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase

      if (start_sel) begin
        if (c == dsi64_pkg::CH_ZERO) begin
          phase_nxt = dsi64_pkg::PH_ZEROS;
          end_nxt   = pos_r + 16'd1;
        end else if (is_dig) begin
          phase_nxt = dsi64_pkg::PH_DIGITS;
          take      = 1'b1;
        end else begin
          phase_nxt = dsi64_pkg::PH_NONUM;
        end
      end

      if (take) begin
        if (dcnt_r >= dsi64_pkg::MAX_DIGITS) begin
          ovf_nxt   = 1'b1;
          phase_nxt = dsi64_pkg::PH_DONE;
        end else begin
          if (too_big) begin
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt = acc10[63:0];
          end
          dcnt_nxt = dcnt_r + 5'd1;
          end_nxt  = pos_r + 16'd1;
        end
      end
    end
  end

  assign has_num = (phase_nxt == dsi64_pkg::PH_ZEROS) || (phase_nxt == dsi64_pkg::PH_DIGITS)
                   || (phase_nxt == dsi64_pkg::PH_DONE);

  always_comb begin
    res.valid = adv && stg.word.last;
    if (!has_num) begin
      res.word.value    = 64'd0;
      res.word.status   = dsi64_pkg::ST_NONUM;
      res.word.consumed = 16'd0;
    end else begin
      res.word.consumed = end_nxt;
      if (ovf_nxt) begin
        res.word.status = dsi64_pkg::ST_RANGE;
        res.word.value  = neg_nxt ? dsi64_pkg::NEG_LIMIT : dsi64_pkg::POS_LIMIT;
      end else if (neg_nxt) begin
        res.word.status = dsi64_pkg::ST_NEG;
        res.word.value  = 64'd0 - acc_nxt;
      end else begin
        res.word.status = dsi64_pkg::ST_POS;
        res.word.value  = acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (adv && stg.word.last)) begin
      phase_r <= dsi64_pkg::PH_WS;
      acc_r   <= 64'd0;
      dcnt_r  <= 5'd0;
      neg_r   <= 1'b0;
      ovf_r   <= 1'b0;
      pos_r   <= 16'd0;
      end_r   <= 16'd0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      dcnt_r  <= dcnt_nxt;
      neg_r   <= neg_nxt;
      ovf_r   <= ovf_nxt;
      pos_r   <= pos_nxt;
      end_r   <= end_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dsi64_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module dsi64_out_stage (
  input  wire                  clk,
  input  wire                  rst_n,
  input  dsi64_pkg::result_t   res,
  output logic                 out_free,
  output logic                 out_valid,
  input  wire                  out_ready,
  output dsi64_pkg::out_word_t out_data
);

  logic                 valid_r;
  dsi64_pkg::out_word_t word_r;

  assign out_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res.valid) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      word_r <= res.word;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = word_r;

endmodule

`default_nettype wire

FILE: sv/decimal_string_to_int64_core.sv
// channel | signals                        | word
// --------+--------------------------------+-------------------------------
// in      | in_valid, in_ready, in_data    | char_byte[7:0], last
// out     | out_valid, out_ready, out_data | value[63:0], status[1:0],
//         |                                | consumed[15:0]
//
// One byte per cycle; the 64-bit times-ten add and limit compare sets the period.
// After its last byte is taken, a result passes two registers: the input register, then
// the result register.
// Reset is synchronous on rst_n and drops both registers and the parse state.
// A stalled result holds back the next last byte and the bytes behind it; earlier bytes keep flowing.
`timescale 1ns / 1ps
`default_nettype none

module decimal_string_to_int64_core (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  dsi64_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output dsi64_pkg::out_word_t out_data
);

  dsi64_pkg::stage_t  stg;
  dsi64_pkg::result_t res;
  logic               adv;
  logic               out_free;

  dsi64_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .adv      (adv),
    .stg      (stg)
  );

  dsi64_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .stg      (stg),
    .out_free (out_free),
    .adv      (adv),
    .res      (res)
  );

  dsi64_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: sv/dsi64_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dsi64_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  out_valid,
  input wire                  out_ready,
  input dsi64_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_nonum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == dsi64_pkg::ST_NONUM)
      |-> (out_data.value == 64'd0) && (out_data.consumed == 16'd0))
    else $error("no-number word carries a value or length");

  a_range_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == dsi64_pkg::ST_RANGE)
      |-> (out_data.value == dsi64_pkg::POS_LIMIT)
          || (out_data.value == dsi64_pkg::NEG_LIMIT))
    else $error("out-of-range word not saturated");

  a_num_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != dsi64_pkg::ST_NONUM) |-> out_data.consumed != 16'd0)
    else $error("parsed number with zero length");

  a_neg_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == dsi64_pkg::ST_NEG)
      |-> out_data.value[63] || (out_data.value == 64'd0))
    else $error("negative word has wrong sign");

endmodule

bind decimal_string_to_int64_core dsi64_checker u_chk (.*);

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_BYTES = 1600;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  dsi64_pkg::in_word_t  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  dsi64_pkg::out_word_t out_data;

  decimal_string_to_int64_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dsi64_pkg::in_word_t  char_stream[$];
  dsi64_pkg::out_word_t parsed_results[$];
  logic [7:0]           text_buf[$];

  dsi64_pkg::phase_t ph;
  logic [63:0]       acc;
  logic [4:0]        ndigits;
  logic              neg;
  logic [15:0]       pos;
  logic [15:0]       end_pos;
  logic [1:0]        sticky_status;

  int                   mismatches  = 0;
  int                   idle_cycles = 0;
  int                   in_gap      = 0;
  int                   in_calm     = 0;
  int                   out_gap     = 0;
  int                   out_calm    = 0;
  int                   base_len;
  dsi64_pkg::out_word_t want;

  task automatic clear_parse;
    begin
      ph            = dsi64_pkg::PH_WS;
      acc           = '0;
      ndigits       = '0;
      neg           = 1'b0;
      pos           = '0;
      end_pos       = '0;
      sticky_status = dsi64_pkg::ST_POS;
    end
  endtask

  task automatic accumulate_digit(input logic [63:0] d);
    logic [63:0] lim;
    begin
      lim = neg ? dsi64_pkg::NEG_LIMIT : dsi64_pkg::POS_LIMIT;
      if (ndigits >= dsi64_pkg::MAX_DIGITS) begin
        sticky_status = dsi64_pkg::ST_RANGE;
        ph = dsi64_pkg::PH_DONE;
      end else begin
        if (acc > (lim - d) / 64'd10) sticky_status = dsi64_pkg::ST_RANGE;
        else acc = acc * 64'd10 + d;
        ndigits = ndigits + 5'd1;
        end_pos = pos + 16'd1;
      end
    end
  endtask

  task automatic begin_number(input logic [7:0] c);
    begin
      if (c == dsi64_pkg::CH_ZERO) begin
        ph = dsi64_pkg::PH_ZEROS;
        end_pos = pos + 16'd1;
      end else if (c >= dsi64_pkg::CH_ZERO && c <= dsi64_pkg::CH_NINE) begin
        ph = dsi64_pkg::PH_DIGITS;
        accumulate_digit(64'(c - dsi64_pkg::CH_ZERO));
      end else begin
        ph = dsi64_pkg::PH_NONUM;
      end
    end
  endtask

  task automatic predict_word(input dsi64_pkg::in_word_t w);
    dsi64_pkg::out_word_t res;
    logic [7:0]           c;
    logic                 dig;
    begin
      c   = w.char_byte;
      dig = (c >= dsi64_pkg::CH_ZERO && c <= dsi64_pkg::CH_NINE);
      if (pos < dsi64_pkg::MAX_LEN) begin
        case (ph)
          dsi64_pkg::PH_WS: begin
            if (c == dsi64_pkg::CH_MINUS) begin
              neg = 1'b1;
              ph = dsi64_pkg::PH_START;
            end else if (c == dsi64_pkg::CH_PLUS) begin
              ph = dsi64_pkg::PH_START;
            end else if (c != dsi64_pkg::CH_SPACE && c != dsi64_pkg::CH_TAB) begin
              begin_number(c);
            end
          end
          dsi64_pkg::PH_START: begin_number(c);
          dsi64_pkg::PH_ZEROS: begin
            if (c == dsi64_pkg::CH_ZERO) end_pos = pos + 16'd1;
            else if (dig) begin
              ph = dsi64_pkg::PH_DIGITS;
              accumulate_digit(64'(c - dsi64_pkg::CH_ZERO));
            end else ph = dsi64_pkg::PH_DONE;
          end
          dsi64_pkg::PH_DIGITS: begin
            if (dig) accumulate_digit(64'(c - dsi64_pkg::CH_ZERO));
            else ph = dsi64_pkg::PH_DONE;
          end
          default: begin
          end
        endcase
        pos = pos + 16'd1;
      end
      if (w.last) begin
        res        = '0;
        res.status = dsi64_pkg::ST_NONUM;
        if (ph == dsi64_pkg::PH_ZEROS || ph == dsi64_pkg::PH_DIGITS ||
            ph == dsi64_pkg::PH_DONE) begin
          res.consumed = end_pos;
          if (sticky_status == dsi64_pkg::ST_RANGE) begin
            res.status = dsi64_pkg::ST_RANGE;
            res.value  = neg ? dsi64_pkg::NEG_LIMIT : dsi64_pkg::POS_LIMIT;
          end else if (neg) begin
            res.status = dsi64_pkg::ST_NEG;
            res.value  = 64'd0 - acc;
          end else begin
            res.status = dsi64_pkg::ST_POS;
            res.value  = acc;
          end
        end
        parsed_results.push_back(res);
        clear_parse();
      end
    end
  endtask

  task automatic add_str(input string s);
    begin
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    end
  endtask

  task automatic emit_text;
    dsi64_pkg::in_word_t w;
    begin
      foreach (text_buf[i]) begin
        w.char_byte = text_buf[i];
        w.last      = (i == text_buf.size() - 1);
        char_stream.push_back(w);
      end
      text_buf.delete();
    end
  endtask

  task automatic send(input string s);
    begin
      add_str(s);
      emit_text();
    end
  endtask

  task automatic append_decimal(input logic [63:0] v);
    logic [7:0]  rev[$];
    logic [63:0] x;
    logic [63:0] r;
    begin
      x = v;
      do begin
        r = x % 64'd10;
        rev.push_front(r[7:0] + dsi64_pkg::CH_ZERO);
        x = x / 64'd10;
      end while (x != 0);
      foreach (rev[i]) text_buf.push_back(rev[i]);
    end
  endtask

  task automatic add_random_string;
    int          kind;
    int          mode;
    logic [63:0] k;
    begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 99) >= 60)
          repeat ($urandom_range(1, 4))
            text_buf.push_back($urandom_range(0, 1) ? dsi64_pkg::CH_SPACE
                                                    : dsi64_pkg::CH_TAB);
        case ($urandom_range(0, 2))
          0: begin
          end
          1: text_buf.push_back(dsi64_pkg::CH_PLUS);
          default: text_buf.push_back(dsi64_pkg::CH_MINUS);
        endcase
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 4)) text_buf.push_back(dsi64_pkg::CH_ZERO);
        mode = $urandom_range(0, 99);
        k    = 64'($urandom_range(0, 1000));
        if (mode < 5) begin
        end else if (mode < 55) begin
          repeat ($urandom_range(1, 20))
            text_buf.push_back(dsi64_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end else if (mode < 70) begin
          if ($urandom_range(0, 1)) append_decimal(dsi64_pkg::POS_LIMIT - k);
          else append_decimal(dsi64_pkg::NEG_LIMIT + k - 64'd500);
        end else if (mode < 80) begin
          add_str("1844674407370955161");
          text_buf.push_back(dsi64_pkg::CH_ZERO + 8'($urandom_range(5, 9)));
        end else if (mode < 90) begin
          repeat ($urandom_range(21, 24))
            text_buf.push_back(dsi64_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end else begin
          repeat ($urandom_range(1, 3))
            text_buf.push_back(dsi64_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(0, 255)));
      end
      if (text_buf.size() == 0) text_buf.push_back(8'($urandom_range(0, 255)));
      emit_text();
    end
  endtask

  task automatic pick_idle(inout int calm, output int gap);
    int r;
    begin
      r = $urandom_range(0, 999);
      if (calm > 0) begin
        calm = calm - 1;
        gap = 0;
      end else if (r < 3) begin
        calm = $urandom_range(50, 200);
        gap = 0;
      end else if (r < 600) gap = 0;
      else if (r < 900) gap = $urandom_range(1, 3);
      else if (r < 985) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_word(in_data);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          in_valid <= 1'b0;
        end else if (char_stream.size() != 0) begin
          in_data  <= char_stream.pop_front();
          in_valid <= 1'b1;
          pick_idle(in_calm, in_gap);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap = out_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      pick_idle(out_calm, out_gap);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (parsed_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected word: value %h status %0d consumed %0d",
                   out_data.value, out_data.status, out_data.consumed);
      end else begin
        want = parsed_results.pop_front();
        if (out_data.value !== want.value || out_data.status !== want.status ||
            out_data.consumed !== want.consumed) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: want value %h status %0d consumed %0d, got %h %0d %0d",
                     want.value, want.status, want.consumed,
                     out_data.value, out_data.status, out_data.consumed);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** decimal_string_to_int64_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    clear_parse();

    send("0");
    send("-0");
    send("+0");
    send("   ");
    send("\t");
    send("-");
    send("+");
    send("x12");
    send("--5");
    send("+-3");
    send("18446744073709551615");
    send("18446744073709551616");
    send("-9223372036854775808");
    send("-9223372036854775809");
    send("123456789012345678901");
    send("99999999999999999999");
    send("000000000000000000000000001");
    send(" \t +42abc");
    send("007x");
    send("  -00");
    text_buf.push_back(8'hFF);
    emit_text();
    add_str("5");
    text_buf.push_back(8'h00);
    emit_text();

    base_len = char_stream.size();
    while (char_stream.size() - base_len < RANDOM_BYTES) add_random_string();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (char_stream.size() != 0 || in_valid) @(posedge clk);
    while (parsed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("** decimal_string_to_int64_core: PASSED **");
    end else begin
      $display("** decimal_string_to_int64_core: FAILED **");
    end
    $finish;
  end

endmodule
